// File: sv/rcsfp_pkg.sv
// Shared types, constants and the CRC helper of the servo frame parser.
package rcsfp_pkg;

	localparam int MAX_CHANNELS_DEF = 16;
	localparam int STORE_DEPTH = 12;
	localparam int STORE_AW = $clog2(STORE_DEPTH);
	localparam int CHAN_W = 16;
	localparam int POS_W = 5;
	localparam int COUNT_W = 4;

	localparam logic [7:0] HEADER_BYTE = 8'd168;
	localparam logic [7:0] MIN_COUNT = 8'd6;
	localparam logic [7:0] MAX_COUNT = 8'd12;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'h0000;

	localparam logic [POS_W-1:0] POS_HEADER = 5'd0;
	localparam logic [POS_W-1:0] POS_STATUS = 5'd1;
	localparam logic [POS_W-1:0] POS_COUNT = 5'd2;
	localparam logic [POS_W-1:0] POS_FIRST_CHAN = 5'd3;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_READ,
		EM_LOAD,
		EM_ERR
	} em_state_t;

	// Request from the parser to the result sequencer.
	typedef struct packed {
		logic go;
		logic err;
		logic [COUNT_W-1:0] count;
	} emit_req_t;

	// Write into the channel store.
	typedef struct packed {
		logic we;
		logic [STORE_AW-1:0] addr;
		logic [CHAN_W-1:0] data;
	} store_wr_t;

	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: sv/rcsfp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rcsfp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/rcsfp_parser.sv
// Byte parser: frame position tracking, running CRC and channel word capture.
module rcsfp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            rx_byte,
	input  logic                  frame_start,
	output rcsfp_pkg::store_wr_t  wr,
	output rcsfp_pkg::emit_req_t  req
);

	logic [rcsfp_pkg::POS_W-1:0]   pos_q, pos_d, eff_pos, crc_hi, off;
	logic [rcsfp_pkg::COUNT_W-1:0] cnt_q, cnt_d, eff_cnt;
	logic [15:0]                   crc_q, crc_d, eff_crc, crc_next;
	logic [7:0]                    hold_q, hold_d;
	logic                          hunt_q, hunt_d;
	logic [15:0]                   rx_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cnt_q  <= '0;
			crc_q  <= rcsfp_pkg::CRC_INIT;
			hold_q <= '0;
			hunt_q <= 1'b1;
		end else begin
			pos_q  <= pos_d;
			cnt_q  <= cnt_d;
			crc_q  <= crc_d;
			hold_q <= hold_d;
			hunt_q <= hunt_d;
		end
	end

	always_comb begin
		// A start flag restarts the frame, so this byte sees the reset state.
		eff_pos  = frame_start ? rcsfp_pkg::POS_HEADER : pos_q;
		eff_cnt  = frame_start ? '0 : cnt_q;
		eff_crc  = frame_start ? rcsfp_pkg::CRC_INIT : crc_q;
		crc_hi   = rcsfp_pkg::POS_FIRST_CHAN + {eff_cnt, 1'b0};
		off      = eff_pos - rcsfp_pkg::POS_FIRST_CHAN;
		crc_next = rcsfp_pkg::crc_add(eff_crc, rx_byte);
		rx_word  = {hold_q, rx_byte};

		pos_d  = pos_q;
		cnt_d  = cnt_q;
		crc_d  = crc_q;
		hold_d = hold_q;
		hunt_d = hunt_q;
		wr     = '0;
		req    = '0;

		if (accept && (frame_start || !hunt_q)) begin
			pos_d  = eff_pos;
			cnt_d  = eff_cnt;
			crc_d  = eff_crc;
			hunt_d = 1'b0;
			if (eff_pos == rcsfp_pkg::POS_HEADER) begin
				if (rx_byte != rcsfp_pkg::HEADER_BYTE) begin
					req.go  = 1'b1;
					req.err = 1'b1;
					hunt_d  = 1'b1;
				end else begin
					crc_d = crc_next;
					pos_d = rcsfp_pkg::POS_STATUS;
				end
			end else if (eff_pos == rcsfp_pkg::POS_STATUS) begin
				crc_d = crc_next;
				pos_d = rcsfp_pkg::POS_COUNT;
			end else if (eff_pos == rcsfp_pkg::POS_COUNT) begin
				if (rx_byte < rcsfp_pkg::MIN_COUNT || rx_byte > rcsfp_pkg::MAX_COUNT) begin
					req.go  = 1'b1;
					req.err = 1'b1;
					hunt_d  = 1'b1;
				end else begin
					cnt_d = rx_byte[rcsfp_pkg::COUNT_W-1:0];
					crc_d = crc_next;
					pos_d = rcsfp_pkg::POS_FIRST_CHAN;
				end
			end else if (eff_pos < crc_hi) begin
				crc_d = crc_next;
				pos_d = eff_pos + 1'b1;
				if (!off[0]) begin
					hold_d = rx_byte;
				end else begin
					wr.we   = 1'b1;
					wr.addr = off[rcsfp_pkg::STORE_AW:1];
					wr.data = rx_word;
				end
			end else if (eff_pos == crc_hi) begin
				hold_d = rx_byte;
				pos_d  = eff_pos + 1'b1;
			end else begin
				// Low byte of the received CRC ends the frame either way.
				hunt_d = 1'b1;
				req.go = 1'b1;
				if (rx_word != eff_crc) begin
					req.err = 1'b1;
				end else begin
					req.count = eff_cnt;
				end
			end
		end
	end

endmodule

// File: sv/rcsfp_emitter.sv
// Result sequencer: reads the channel store and drives the output register.
module rcsfp_emitter #(
	parameter int MAX_CHANNELS = rcsfp_pkg::MAX_CHANNELS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rcsfp_pkg::emit_req_t                 req,
	output logic                                 busy,
	output logic                                 rd_en,
	output logic [rcsfp_pkg::STORE_AW-1:0]       rd_addr,
	input  logic [rcsfp_pkg::CHAN_W-1:0]         rd_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [3:0]                           chan_index,
	output logic [rcsfp_pkg::CHAN_W-1:0]         chan_value,
	output logic [rcsfp_pkg::COUNT_W-1:0]        chan_count,
	output logic                                 last_of_run
);

	localparam int KW = $clog2(MAX_CHANNELS);
	localparam logic [KW-1:0] K_LAST = KW'(MAX_CHANNELS - 1);

	rcsfp_pkg::em_state_t state_q, state_d;
	logic [KW-1:0]                   k_q;
	logic [rcsfp_pkg::COUNT_W-1:0]   n_q;
	logic                            out_valid_q;
	logic [3:0]                      index_q;
	logic [rcsfp_pkg::CHAN_W-1:0]    value_q;
	logic [rcsfp_pkg::COUNT_W-1:0]   count_q;
	logic                            last_q;
	logic                            out_free, in_range, is_last, load_run, load_err;

	assign out_free = !out_valid_q || out_ready;
	assign in_range = k_q < KW'(n_q);
	assign is_last  = k_q == K_LAST;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rcsfp_pkg::EM_IDLE: begin
				if (req.go) begin
					state_d = req.err ? rcsfp_pkg::EM_ERR : rcsfp_pkg::EM_READ;
				end
			end
			rcsfp_pkg::EM_READ: state_d = rcsfp_pkg::EM_LOAD;
			rcsfp_pkg::EM_LOAD: begin
				if (out_free) begin
					state_d = is_last ? rcsfp_pkg::EM_IDLE : rcsfp_pkg::EM_READ;
				end
			end
			rcsfp_pkg::EM_ERR: begin
				if (out_free) begin
					state_d = rcsfp_pkg::EM_IDLE;
				end
			end
			default: state_d = rcsfp_pkg::EM_IDLE;
		endcase
	end

	always_comb begin
		busy     = state_q != rcsfp_pkg::EM_IDLE;
		rd_en    = (state_q == rcsfp_pkg::EM_READ) && in_range;
		rd_addr  = k_q[rcsfp_pkg::STORE_AW-1:0];
		load_run = (state_q == rcsfp_pkg::EM_LOAD) && out_free;
		load_err = (state_q == rcsfp_pkg::EM_ERR) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rcsfp_pkg::EM_IDLE;
			k_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rcsfp_pkg::EM_IDLE && req.go) begin
				k_q <= '0;
				n_q <= req.count;
			end else if (load_run) begin
				k_q <= k_q + 1'b1;
			end
			if (load_run || load_err) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_run) begin
			index_q <= k_q[3:0];
			value_q <= in_range ? rd_data : '0;
			count_q <= n_q;
			last_q  <= is_last;
		end else if (load_err) begin
			index_q <= '0;
			value_q <= '0;
			count_q <= '0;
			last_q  <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign chan_index  = index_q;
	assign chan_value  = value_q;
	assign chan_count  = count_q;
	assign last_of_run = last_q;

`ifndef ASSERT_OFF
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && count_q == '0 |-> last_q && value_q == '0 && index_q == '0)
		else $error("error result has wrong fields");
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && count_q != '0 && last_q |-> index_q == K_LAST[3:0])
		else $error("last result of a frame at wrong index");
	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rcsfp_pkg::EM_LOAD |-> $past(state_q) == rcsfp_pkg::EM_READ
		|| $past(state_q) == rcsfp_pkg::EM_LOAD)
		else $error("load without a store read");
`endif

endmodule

// File: sv/rc_servo_frame_parser_crc16.sv
// Top level of the radio-control servo frame parser with CRC-16 check.
// Takes one frame byte per transfer and checks header, channel count and a
// CRC-16 XMODEM. Channel words are kept in a small synchronous RAM. Bytes
// flow at one per clock while no results are pending. A good frame then gives
// MAX_CHANNELS results; the result sequencer does a RAM read and then an
// output load for each, and input is held off until the last one is loaded,
// output stalls included. A bad frame gives one error result and holds input
// off until that result is loaded. Input is accepted while the last result
// still waits in the output register.
// No clearing pass runs after reset.
module rc_servo_frame_parser_crc16 #(
	parameter int MAX_CHANNELS = rcsfp_pkg::MAX_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  chan_index,
	output logic [15:0] chan_value,
	output logic [3:0]  chan_count,
	output logic        last_of_run
);

	rcsfp_pkg::store_wr_t                 wr;
	rcsfp_pkg::emit_req_t                 req;
	logic                                 accept, busy, rd_en;
	logic [rcsfp_pkg::STORE_AW-1:0]       rd_addr;
	logic [rcsfp_pkg::CHAN_W-1:0]         rd_data;

	// Holding input off during a result burst keeps store writes and reads apart.
	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;

	rcsfp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.wr          (wr),
		.req         (req)
	);

	rcsfp_ram #(
		.WIDTH (rcsfp_pkg::CHAN_W),
		.DEPTH (rcsfp_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rcsfp_emitter #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.busy        (busy),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.chan_index  (chan_index),
		.chan_value  (chan_value),
		.chan_count  (chan_count),
		.last_of_run (last_of_run)
	);

`ifndef ASSERT_OFF
	a_no_write_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> !busy && !rd_en)
		else $error("store write during a result burst");
	a_req_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |=> !in_ready)
		else $error("input taken right after a frame ended");
	a_req_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.go || wr.we |-> accept)
		else $error("parser acted without an input transfer");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the servo frame parser with CRC-16 frame check.

localparam int NUM_RESULTS = rcsfp_pkg::MAX_CHANNELS_DEF;

typedef struct packed {
	logic [3:0] idx;
	logic [15:0] value;
	logic [3:0] count;
	logic last;
} chan_result_t;

class servo_frame_board;
	chan_result_t awaited_channels[$];
	int mismatches;

	logic [rcsfp_pkg::POS_W-1:0] frame_pos;
	logic [rcsfp_pkg::COUNT_W-1:0] frame_chans;
	logic [15:0] frame_crc;
	logic [7:0] high_byte;
	logic [15:0] chan_words[rcsfp_pkg::STORE_DEPTH];
	logic hunting;

	function new();
		mismatches = 0;
		frame_pos = rcsfp_pkg::POS_HEADER;
		frame_chans = '0;
		frame_crc = rcsfp_pkg::CRC_INIT;
		high_byte = '0;
		hunting = 1'b1;
		foreach (chan_words[i]) chan_words[i] = '0;
	endfunction

	// Bit-serial form of the XMODEM CRC, one message bit per step.
	function logic [15:0] crc_next(logic [15:0] acc, logic [7:0] b);
		logic [15:0] r;
		logic feedback;
		r = acc;
		for (int bit_i = 7; bit_i >= 0; bit_i--) begin
			feedback = r[15] ^ b[bit_i];
			r = {r[14:0], 1'b0};
			if (feedback) r = r ^ rcsfp_pkg::CRC_POLY;
		end
		return r;
	endfunction

	function void push_error();
		chan_result_t res;
		res.idx = '0;
		res.value = '0;
		res.count = '0;
		res.last = 1'b1;
		awaited_channels.push_back(res);
		hunting = 1'b1;
	endfunction

	function void note_byte(logic [7:0] b, logic start);
		int crc_hi_pos;
		int off;
		chan_result_t res;
		if (start) begin
			frame_pos = rcsfp_pkg::POS_HEADER;
			frame_crc = rcsfp_pkg::CRC_INIT;
			frame_chans = '0;
			hunting = 1'b0;
		end else if (hunting) begin
			return;
		end
		crc_hi_pos = int'(rcsfp_pkg::POS_FIRST_CHAN) + 2 * int'(frame_chans);
		if (frame_pos == rcsfp_pkg::POS_HEADER) begin
			if (b != rcsfp_pkg::HEADER_BYTE) begin
				push_error();
				return;
			end
			frame_crc = crc_next(frame_crc, b);
			frame_pos = rcsfp_pkg::POS_STATUS;
		end else if (frame_pos == rcsfp_pkg::POS_STATUS) begin
			frame_crc = crc_next(frame_crc, b);
			frame_pos = rcsfp_pkg::POS_COUNT;
		end else if (frame_pos == rcsfp_pkg::POS_COUNT) begin
			if (b < rcsfp_pkg::MIN_COUNT || b > rcsfp_pkg::MAX_COUNT) begin
				push_error();
				return;
			end
			frame_chans = b[rcsfp_pkg::COUNT_W-1:0];
			frame_crc = crc_next(frame_crc, b);
			frame_pos = rcsfp_pkg::POS_FIRST_CHAN;
		end else if (int'(frame_pos) < crc_hi_pos) begin
			off = int'(frame_pos) - int'(rcsfp_pkg::POS_FIRST_CHAN);
			frame_crc = crc_next(frame_crc, b);
			if (off % 2 == 0) high_byte = b;
			else if (off / 2 < rcsfp_pkg::STORE_DEPTH) chan_words[off / 2] = {high_byte, b};
			frame_pos = frame_pos + 1'b1;
		end else if (int'(frame_pos) == crc_hi_pos) begin
			high_byte = b;
			frame_pos = frame_pos + 1'b1;
		end else begin
			// Low CRC byte closes the frame either way.
			hunting = 1'b1;
			if ({high_byte, b} != frame_crc) begin
				push_error();
				return;
			end
			for (int k = 0; k < NUM_RESULTS; k++) begin
				res.idx = k[3:0];
				res.value = (k < int'(frame_chans) && k < rcsfp_pkg::STORE_DEPTH)
					? chan_words[k] : '0;
				res.count = frame_chans;
				res.last = (k == NUM_RESULTS - 1);
				awaited_channels.push_back(res);
			end
		end
	endfunction

	function void check_channel(chan_result_t got);
		chan_result_t want;
		if (awaited_channels.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: idx=%0d value=%h count=%0d last=%b",
					got.idx, got.value, got.count, got.last);
			return;
		end
		want = awaited_channels.pop_front();
		if (got.idx != want.idx || got.value != want.value || got.count != want.count ||
				got.last != want.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch: expected idx=%0d value=%h count=%0d last=%b, ",
					"got idx=%0d value=%h count=%0d last=%b"},
					want.idx, want.value, want.count, want.last,
					got.idx, got.value, got.count, got.last);
		end
	endfunction

	function int pending();
		return awaited_channels.size();
	endfunction
endclass

module testbench;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RX_HOLD_CYCLES = 300;

	typedef enum {
		FK_GOOD,
		FK_BAD_HEADER,
		FK_BAD_COUNT,
		FK_BAD_CRC,
		FK_CUT
	} frame_kind_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] rx_byte;
	logic frame_start;
	logic out_valid;
	logic out_ready;
	logic [3:0] chan_index;
	logic [15:0] chan_value;
	logic [3:0] chan_count;
	logic last_of_run;

	servo_frame_board board = new();
	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_request;
	int hold_left;
	int cycles;
	logic [15:0] frame_words[rcsfp_pkg::STORE_DEPTH];
	logic [7:0] frame_status;
	logic [7:0] frame_bytes[$];

	rc_servo_frame_parser_crc16 #(
		.MAX_CHANNELS(NUM_RESULTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chan_index(chan_index),
		.chan_value(chan_value),
		.chan_count(chan_count),
		.last_of_run(last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Valid is only dropped for an idle cycle, never around a back-to-back transfer.
	task automatic send_byte(input logic [7:0] b, input logic start);
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_start <= start;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_byte(b, start);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic send_frame(input int n, input frame_kind_t kind, input logic [7:0] bad_byte);
		logic [15:0] crc;
		int len;
		frame_bytes = {rcsfp_pkg::HEADER_BYTE, frame_status, n[7:0]};
		for (int i = 0; i < n; i++) begin
			frame_bytes.push_back(frame_words[i][15:8]);
			frame_bytes.push_back(frame_words[i][7:0]);
		end
		crc = rcsfp_pkg::CRC_INIT;
		foreach (frame_bytes[i]) crc = board.crc_next(crc, frame_bytes[i]);
		frame_bytes.push_back(crc[15:8]);
		frame_bytes.push_back(crc[7:0]);
		len = frame_bytes.size();
		case (kind)
			FK_BAD_HEADER: begin
				frame_bytes[0] = bad_byte;
				len = 3;
			end
			FK_BAD_COUNT: begin
				frame_bytes[2] = bad_byte;
				len = 4;
			end
			FK_BAD_CRC: begin
				frame_bytes[len - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
			end
			FK_CUT: begin
				len = $urandom_range(1, len - 1);
			end
			default: begin
			end
		endcase
		for (int i = 0; i < len; i++) send_byte(frame_bytes[i], i == 0);
	endtask

	task automatic fill_random_words();
		for (int i = 0; i < rcsfp_pkg::STORE_DEPTH; i++) begin
			case ($urandom_range(0, 5))
				0: frame_words[i] = 16'h0000;
				1: frame_words[i] = 16'hFFFF;
				2: frame_words[i] = 16'h8000;
				3: frame_words[i] = 16'h7FFF;
				default: frame_words[i] = 16'($urandom_range(0, 65535));
			endcase
		end
		frame_status = 8'($urandom_range(0, 255));
	endtask

	task automatic random_frame();
		int roll;
		int n;
		logic [7:0] bad;
		fill_random_words();
		n = $urandom_range(int'(rcsfp_pkg::MIN_COUNT), int'(rcsfp_pkg::MAX_COUNT));
		roll = $urandom_range(99);
		if (roll < 62) begin
			send_frame(n, FK_GOOD, '0);
		end else if (roll < 72) begin
			send_frame(n, FK_BAD_CRC, '0);
		end else if (roll < 80) begin
			send_frame(n, FK_CUT, '0);
		end else if (roll < 90) begin
			bad = $urandom_range(0, 1)
				? 8'($urandom_range(0, int'(rcsfp_pkg::MIN_COUNT) - 1))
				: 8'($urandom_range(int'(rcsfp_pkg::MAX_COUNT) + 1, 255));
			send_frame(n, FK_BAD_COUNT, bad);
		end else begin
			do bad = 8'($urandom_range(0, 255)); while (bad == rcsfp_pkg::HEADER_BYTE);
			send_frame(n, FK_BAD_HEADER, bad);
		end
		// Stray bytes between frames; ignored unless a frame was left open.
		if ($urandom_range(99) < 20)
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_channel({chan_index, chan_value, chan_count, last_of_run});
			if (hold_request) begin
				hold_left = RX_HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		frame_start = 1'b0;
		hold_request = 1'b0;
		tx_idle_pct = 11;
		rx_idle_pct = 11;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes before any start flag are dropped.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(rcsfp_pkg::HEADER_BYTE, 1'b0);

		frame_words[0] = 16'h0000;
		frame_words[1] = 16'hFFFF;
		frame_words[2] = 16'h8000;
		frame_words[3] = 16'h7FFF;
		frame_words[4] = 16'h00FF;
		frame_words[5] = 16'hFF00;
		frame_status = 8'h00;
		send_frame(int'(rcsfp_pkg::MIN_COUNT), FK_GOOD, '0);
		send_byte(rcsfp_pkg::HEADER_BYTE, 1'b0);
		send_byte(8'h5A, 1'b0);

		for (int i = 0; i < rcsfp_pkg::STORE_DEPTH; i++)
			frame_words[i] = i[0] ? 16'hFFFF - 16'(i) : 16'h0000 + 16'(i << 11);
		frame_status = 8'hFF;
		send_frame(int'(rcsfp_pkg::MAX_COUNT), FK_GOOD, '0);

		send_frame(int'(rcsfp_pkg::MIN_COUNT), FK_BAD_HEADER, 8'h00);
		send_frame(int'(rcsfp_pkg::MIN_COUNT), FK_BAD_HEADER, rcsfp_pkg::HEADER_BYTE + 8'd1);
		send_frame(int'(rcsfp_pkg::MIN_COUNT), FK_BAD_COUNT, rcsfp_pkg::MIN_COUNT - 8'd1);
		send_frame(int'(rcsfp_pkg::MIN_COUNT), FK_BAD_COUNT, rcsfp_pkg::MAX_COUNT + 8'd1);
		send_frame(int'(rcsfp_pkg::MIN_COUNT), FK_BAD_COUNT, 8'd0);
		send_frame(int'(rcsfp_pkg::MIN_COUNT), FK_BAD_COUNT, 8'd255);
		send_frame(7, FK_BAD_CRC, '0);
		send_frame(9, FK_CUT, '0);
		send_frame(int'(rcsfp_pkg::MIN_COUNT), FK_GOOD, '0);
		wait_drained();

		// Receiver holds off while good frames keep coming, so the input stalls.
		hold_request = 1'b1;
		repeat (2) begin
			fill_random_words();
			send_frame($urandom_range(int'(rcsfp_pkg::MIN_COUNT), int'(rcsfp_pkg::MAX_COUNT)),
				FK_GOOD, '0);
		end
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (2) random_frame();
		tx_idle_pct = 11;
		rx_idle_pct = 11;

		wait_drained();
		repeat (4 * NUM_RESULTS + 20) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// File: files.f
sv/rcsfp_pkg.sv
sv/rcsfp_ram.sv
sv/rcsfp_parser.sv
sv/rcsfp_emitter.sv
sv/rc_servo_frame_parser_crc16.sv
tb/testbench.sv
